// File: rtl/wpd_pkg.sv
// Shared types and constants of the WAV stream parser and PCM decoder.
package wpd_pkg;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [15:0] FormatFloat = 16'd3;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_CTAG,
    PH_CLEN,
    PH_BODY,
    PH_PAD,
    PH_DATA,
    PH_DONE,
    PH_DEAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_REPORT,
    KIND_FAIL,
    KIND_END
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_MAGIC,
    ERR_TRUNC,
    ERR_CHANNELS,
    ERR_ORDER,
    ERR_BITS
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic               channel;
    logic signed [31:0] sample_value;
    logic               is_float;
    logic        [15:0] format_tag;
    logic        [15:0] channel_count;
    logic        [31:0] rate_hz;
    logic        [15:0] bits_per_sample;
    logic        [31:0] data_len;
    err_e               error_code;
    logic               last;
  } res_t;

endpackage

// File: rtl/wpd_byte_if.sv
// Byte channel carrying the WAV file into the parser.
interface wpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;

  modport source (output valid, output byte_in, output end_of_file, input ready);
  modport sink   (input valid, input byte_in, input end_of_file, output ready);
endinterface

// File: rtl/wpd_result_if.sv
// Result channel carrying samples, format reports and status words.
interface wpd_result_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic               channel;
  logic signed [31:0] sample_value;
  logic               is_float;
  logic        [15:0] format_tag;
  logic        [15:0] channel_count;
  logic        [31:0] rate_hz;
  logic        [15:0] bits_per_sample;
  logic        [31:0] data_len;
  logic        [2:0]  error_code;
  logic               last;

  modport source (output valid, output kind, output channel, output sample_value,
                  output is_float, output format_tag, output channel_count,
                  output rate_hz, output bits_per_sample, output data_len,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input channel, input sample_value,
                  input is_float, input format_tag, input channel_count,
                  input rate_hz, input bits_per_sample, input data_len,
                  input error_code, input last, output ready);
endinterface

// File: rtl/wav_stream_parse_decode.sv
// Top level: RIFF/WAVE byte parser, PCM decoder and result queue.
//
//  channel  dir  word                          notes
//  in_i     in   byte_in[7:0], end_of_file     one file byte per word
//  out_o    out  kind, channel, sample_value,  0..2 words per input byte,
//                fmt fields, error_code, last  last set on the final one
//
// One byte is taken per cycle; its results land in a 4-word queue the same edge.
// in_i.ready is high while the queue has room for two words, so bytes flow
// every cycle as long as out_o drains about one word per cycle.
// A stalled out_o fills the queue and then holds in_i.ready low.
// rst_ni clears the parser to its wait-for-RIFF state and empties the queue;
// the final byte of a file returns the parser to that state on its own.
module wav_stream_parse_decode (
  input  logic clk_i,
  input  logic rst_ni,
  wpd_byte_if.sink     in_i,
  wpd_result_if.source out_o
);

  // Parser state
  wpd_pkg::phase_e phase_q, phase_d, phase_step;
  logic [31:0] byte_count_q, byte_count_d;
  logic [31:0] chunk_tag_q, chunk_tag_d;
  logic [31:0] chunk_length_q, chunk_length_d;
  logic        format_seen_q, format_seen_d;
  logic [15:0] stored_tag_q, stored_tag_d;
  logic [15:0] stored_channels_q, stored_channels_d;
  logic [31:0] stored_rate_q, stored_rate_d;
  logic [15:0] stored_bits_q, stored_bits_d;
  logic [31:0] remaining_q, remaining_d;
  logic [31:0] assembly_q, assembly_d;
  logic [2:0]  sidx_q, sidx_d;
  logic [31:0] held_q, held_d;
  logic        chan_idx_q, chan_idx_d;
  logic [1:0]  mod3_q, mod3_d;

  // Result queue
  wpd_pkg::res_t                  fifo_q [wpd_pkg::FifoDepth];
  logic [wpd_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [wpd_pkg::FifoCntW-1:0]   count_q, count_d;

  logic          in_acc, out_pop;
  wpd_pkg::res_t res [2];
  logic [1:0]    n_res;

  logic [31:0] shifted_tag, shifted_len, cnt_inc, asm_full, sample_v, remaining_new;
  logic        word_done, is_data_tag, is_fmt_tag, sample_done;
  logic [2:0]  bytes_per, frame_rem;
  logic [1:0]  len_mod3, r6_sel;
  wpd_pkg::err_e fmt_err, fail_code;

  function automatic logic [1:0] mod3_reduce(input logic [2:0] v);
    logic [2:0] t;
    t = v;
    if (t >= 3'd3) t = t - 3'd3;
    if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // 256, 16 and 4 are all 1 mod 3, so a byte reduces by summing 2-bit digits
  function automatic logic [1:0] byte_mod3(input logic [7:0] b);
    logic [3:0] s;
    logic [2:0] s2;
    s  = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
    s2 = 3'(s[1:0]) + 3'(s[3:2]);
    return mod3_reduce(s2);
  endfunction

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_pop = out_o.valid && out_o.ready;

  assign shifted_tag = {in_i.byte_in, chunk_tag_q[31:8]};
  assign shifted_len = {in_i.byte_in, chunk_length_q[31:8]};
  assign cnt_inc     = byte_count_q + 32'd1;
  assign word_done   = (byte_count_q[1:0] == 2'd3);
  assign is_data_tag = (chunk_tag_q == wpd_pkg::TagData);
  assign is_fmt_tag  = (chunk_tag_q == wpd_pkg::TagFmt);

  // Length mod 3 accumulates over the four length bytes
  assign len_mod3 = mod3_reduce(3'((byte_count_q[1:0] == 2'd0) ? 2'd0 : mod3_q)
                                + 3'(byte_mod3(in_i.byte_in)));

  // Format check: order, then channels, then width
  always_comb begin
    if (!format_seen_q) begin
      fmt_err = wpd_pkg::ERR_ORDER;
    end else if (stored_channels_q != 16'd1 && stored_channels_q != 16'd2) begin
      fmt_err = wpd_pkg::ERR_CHANNELS;
    end else if (stored_tag_q == wpd_pkg::FormatFloat) begin
      fmt_err = (stored_bits_q == 16'd32) ? wpd_pkg::ERR_NONE : wpd_pkg::ERR_BITS;
    end else if (stored_bits_q == 16'd8 || stored_bits_q == 16'd16 ||
                 stored_bits_q == 16'd24 || stored_bits_q == 16'd32) begin
      fmt_err = wpd_pkg::ERR_NONE;
    end else begin
      fmt_err = wpd_pkg::ERR_BITS;
    end
  end

  // Valid formats only reach here, so bits[5:3] is the sample size in bytes
  assign bytes_per = stored_bits_q[5:3];

  always_comb begin
    case ({len_mod3, shifted_len[0]})
      3'b000:  r6_sel = 2'd0;
      3'b001:  r6_sel = 2'd3;
      3'b010:  r6_sel = 2'd0;
      3'b011:  r6_sel = 2'd1;
      3'b100:  r6_sel = 2'd2;
      3'b101:  r6_sel = 2'd1;
      default: r6_sel = 2'd0;
    endcase
  end

  // Drop the partial frame at the end of the data chunk
  always_comb begin
    frame_rem = 3'd0;
    case (bytes_per)
      3'd1: frame_rem = (stored_channels_q == 16'd1) ? 3'd0 : {2'b00, shifted_len[0]};
      3'd2: frame_rem = (stored_channels_q == 16'd1) ? {2'b00, shifted_len[0]}
                                                     : {1'b0, shifted_len[1:0]};
      3'd3: begin
        if (stored_channels_q == 16'd1) begin
          frame_rem = {1'b0, len_mod3};
        end else begin
          // mod 6 from mod 3 and parity; r6_sel folds 4 and 5 onto 0 and 1
          frame_rem = (r6_sel == 2'd1 && len_mod3 == 2'd2) ? 3'd5
                    : (r6_sel == 2'd0 && len_mod3 == 2'd1) ? 3'd4
                    : {1'b0, r6_sel};
        end
      end
      3'd4: frame_rem = (stored_channels_q == 16'd1) ? {1'b0, shifted_len[1:0]}
                                                     : shifted_len[2:0];
      default: frame_rem = 3'd0;
    endcase
  end

  assign remaining_new = shifted_len - 32'(frame_rem);

  // Sample assembly and alignment of PCM samples to Q1.31; float samples pass through as raw bits
  assign asm_full    = assembly_q | (32'(in_i.byte_in) << {sidx_q[1:0], 3'b000});
  assign sample_done = (3'(sidx_q + 3'd1) >= bytes_per);

  always_comb begin
    if (stored_tag_q == wpd_pkg::FormatFloat) begin
      sample_v = asm_full;
    end else begin
      case (bytes_per)
        3'd1:    sample_v = (asm_full << 24) ^ 32'h8000_0000;
        3'd2:    sample_v = asm_full << 16;
        3'd3:    sample_v = asm_full << 8;
        default: sample_v = asm_full;
      endcase
    end
  end

  always_comb begin
    fail_code = wpd_pkg::ERR_NONE;
    case (phase_q)
      wpd_pkg::PH_RIFF: begin
        if (word_done && shifted_tag != wpd_pkg::TagRiff) fail_code = wpd_pkg::ERR_MAGIC;
      end
      wpd_pkg::PH_WAVE: begin
        if (word_done && shifted_tag != wpd_pkg::TagWave) fail_code = wpd_pkg::ERR_MAGIC;
      end
      wpd_pkg::PH_CLEN: begin
        if (word_done && is_data_tag) fail_code = fmt_err;
      end
      default: fail_code = wpd_pkg::ERR_NONE;
    endcase
  end

  // Next phase
  always_comb begin
    phase_step = phase_q;
    unique case (phase_q)
      wpd_pkg::PH_RIFF:  if (word_done) phase_step = wpd_pkg::PH_RSIZE;
      wpd_pkg::PH_RSIZE: if (word_done) phase_step = wpd_pkg::PH_WAVE;
      wpd_pkg::PH_WAVE:  if (word_done) phase_step = wpd_pkg::PH_CTAG;
      wpd_pkg::PH_CTAG:  if (word_done) phase_step = wpd_pkg::PH_CLEN;
      wpd_pkg::PH_CLEN: begin
        if (word_done) begin
          if (is_data_tag) begin
            phase_step = (remaining_new != 32'd0) ? wpd_pkg::PH_DATA : wpd_pkg::PH_DONE;
          end else begin
            phase_step = (shifted_len != 32'd0) ? wpd_pkg::PH_BODY : wpd_pkg::PH_CTAG;
          end
        end
      end
      wpd_pkg::PH_BODY: begin
        if (cnt_inc == chunk_length_q) begin
          phase_step = chunk_length_q[0] ? wpd_pkg::PH_PAD : wpd_pkg::PH_CTAG;
        end
      end
      wpd_pkg::PH_PAD:  phase_step = wpd_pkg::PH_CTAG;
      wpd_pkg::PH_DATA: if (remaining_q == 32'd1) phase_step = wpd_pkg::PH_DONE;
      wpd_pkg::PH_DONE: phase_step = wpd_pkg::PH_DONE;
      wpd_pkg::PH_DEAD: phase_step = wpd_pkg::PH_DEAD;
      default:          phase_step = wpd_pkg::PH_RIFF;
    endcase
    if (fail_code != wpd_pkg::ERR_NONE) phase_step = wpd_pkg::PH_DEAD;
    phase_d = in_i.end_of_file ? wpd_pkg::PH_RIFF : phase_step;
  end

  // Datapath updates and result words
  always_comb begin
    byte_count_d      = byte_count_q;
    chunk_tag_d       = chunk_tag_q;
    chunk_length_d    = chunk_length_q;
    format_seen_d     = format_seen_q;
    stored_tag_d      = stored_tag_q;
    stored_channels_d = stored_channels_q;
    stored_rate_d     = stored_rate_q;
    stored_bits_d     = stored_bits_q;
    remaining_d       = remaining_q;
    assembly_d        = assembly_q;
    sidx_d            = sidx_q;
    held_d            = held_q;
    chan_idx_d        = chan_idx_q;
    mod3_d            = mod3_q;
    res[0]            = '0;
    res[1]            = '0;
    n_res             = 2'd0;

    case (phase_q)
      wpd_pkg::PH_RIFF, wpd_pkg::PH_RSIZE, wpd_pkg::PH_WAVE, wpd_pkg::PH_CTAG: begin
        chunk_tag_d  = shifted_tag;
        byte_count_d = word_done ? 32'd0 : cnt_inc;
      end
      wpd_pkg::PH_CLEN: begin
        chunk_length_d = shifted_len;
        mod3_d         = len_mod3;
        byte_count_d   = word_done ? 32'd0 : cnt_inc;
        if (word_done) begin
          if (is_data_tag) begin
            if (fmt_err == wpd_pkg::ERR_NONE) begin
              remaining_d                  = remaining_new;
              assembly_d                   = 32'd0;
              sidx_d                       = 3'd0;
              chan_idx_d                   = 1'b0;
              res[0].kind                  = wpd_pkg::KIND_REPORT;
              res[0].is_float              = (stored_tag_q == wpd_pkg::FormatFloat);
              res[0].format_tag            = stored_tag_q;
              res[0].channel_count         = stored_channels_q;
              res[0].rate_hz               = stored_rate_q;
              res[0].bits_per_sample       = stored_bits_q;
              res[0].data_len              = shifted_len;
              n_res                        = 2'd1;
            end
          end else if (is_fmt_tag) begin
            format_seen_d     = 1'b1;
            stored_tag_d      = 16'd0;
            stored_channels_d = 16'd0;
            stored_rate_d     = 32'd0;
            stored_bits_d     = 16'd0;
          end
        end
      end
      wpd_pkg::PH_BODY: begin
        if (is_fmt_tag && byte_count_q < 32'd16) begin
          case (byte_count_q[3:0])
            4'd0:    stored_tag_d[7:0]       = in_i.byte_in;
            4'd1:    stored_tag_d[15:8]      = in_i.byte_in;
            4'd2:    stored_channels_d[7:0]  = in_i.byte_in;
            4'd3:    stored_channels_d[15:8] = in_i.byte_in;
            4'd4:    stored_rate_d[7:0]      = in_i.byte_in;
            4'd5:    stored_rate_d[15:8]     = in_i.byte_in;
            4'd6:    stored_rate_d[23:16]    = in_i.byte_in;
            4'd7:    stored_rate_d[31:24]    = in_i.byte_in;
            4'd14:   stored_bits_d[7:0]      = in_i.byte_in;
            4'd15:   stored_bits_d[15:8]     = in_i.byte_in;
            default: stored_bits_d           = stored_bits_q;
          endcase
        end
        byte_count_d = (cnt_inc == chunk_length_q) ? 32'd0 : cnt_inc;
      end
      wpd_pkg::PH_DATA: begin
        remaining_d = remaining_q - 32'd1;
        if (sample_done) begin
          assembly_d = 32'd0;
          sidx_d     = 3'd0;
          if (stored_channels_q == 16'd1) begin
            res[0].kind         = wpd_pkg::KIND_SAMPLE;
            res[0].sample_value = sample_v;
            res[0].is_float     = (stored_tag_q == wpd_pkg::FormatFloat);
            n_res               = 2'd1;
          end else if (!chan_idx_q) begin
            // hold the left sample until the frame is whole
            held_d     = sample_v;
            chan_idx_d = 1'b1;
          end else begin
            res[0].kind         = wpd_pkg::KIND_SAMPLE;
            res[0].sample_value = held_q;
            res[0].is_float     = (stored_tag_q == wpd_pkg::FormatFloat);
            res[1].kind         = wpd_pkg::KIND_SAMPLE;
            res[1].channel      = 1'b1;
            res[1].sample_value = sample_v;
            res[1].is_float     = (stored_tag_q == wpd_pkg::FormatFloat);
            n_res               = 2'd2;
            chan_idx_d          = 1'b0;
          end
        end else begin
          assembly_d = asm_full;
          sidx_d     = 3'(sidx_q + 3'd1);
        end
      end
      default: byte_count_d = byte_count_q;
    endcase

    if (fail_code != wpd_pkg::ERR_NONE) begin
      res[n_res[0]].kind       = wpd_pkg::KIND_FAIL;
      res[n_res[0]].error_code = fail_code;
      n_res                    = 2'(n_res + 2'd1);
    end

    if (in_i.end_of_file) begin
      if (phase_step != wpd_pkg::PH_DEAD && n_res != 2'd2) begin
        if (phase_step == wpd_pkg::PH_DONE) begin
          res[n_res[0]].kind       = wpd_pkg::KIND_END;
        end else begin
          res[n_res[0]].kind       = wpd_pkg::KIND_FAIL;
          res[n_res[0]].error_code = wpd_pkg::ERR_TRUNC;
        end
        n_res = 2'(n_res + 2'd1);
      end
      // back to the reset state for the next file
      byte_count_d      = 32'd0;
      chunk_tag_d       = 32'd0;
      chunk_length_d    = 32'd0;
      format_seen_d     = 1'b0;
      stored_tag_d      = 16'd0;
      stored_channels_d = 16'd0;
      stored_rate_d     = 32'd0;
      stored_bits_d     = 16'd0;
      remaining_d       = 32'd0;
      assembly_d        = 32'd0;
      sidx_d            = 3'd0;
      held_d            = 32'd0;
      chan_idx_d        = 1'b0;
      mod3_d            = 2'd0;
    end

    if (n_res == 2'd1) res[0].last = 1'b1;
    if (n_res == 2'd2) res[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= wpd_pkg::PH_RIFF;
      byte_count_q      <= '0;
      chunk_tag_q       <= '0;
      chunk_length_q    <= '0;
      format_seen_q     <= 1'b0;
      stored_tag_q      <= '0;
      stored_channels_q <= '0;
      stored_rate_q     <= '0;
      stored_bits_q     <= '0;
      remaining_q       <= '0;
      assembly_q        <= '0;
      sidx_q            <= '0;
      held_q            <= '0;
      chan_idx_q        <= 1'b0;
      mod3_q            <= '0;
    end else if (in_acc) begin
      phase_q           <= phase_d;
      byte_count_q      <= byte_count_d;
      chunk_tag_q       <= chunk_tag_d;
      chunk_length_q    <= chunk_length_d;
      format_seen_q     <= format_seen_d;
      stored_tag_q      <= stored_tag_d;
      stored_channels_q <= stored_channels_d;
      stored_rate_q     <= stored_rate_d;
      stored_bits_q     <= stored_bits_d;
      remaining_q       <= remaining_d;
      assembly_q        <= assembly_d;
      sidx_q            <= sidx_d;
      held_q            <= held_d;
      chan_idx_q        <= chan_idx_d;
      mod3_q            <= mod3_d;
    end
  end

  // Result queue: up to two words pushed per accepted byte, one popped per cycle while out_o.ready is high
  assign in_i.ready = (count_q < wpd_pkg::FifoCntW'(wpd_pkg::FifoDepth - 1));

  always_comb begin
    count_d = count_q;
    if (in_acc) count_d = wpd_pkg::FifoCntW'(count_d + wpd_pkg::FifoCntW'(n_res));
    if (out_pop) count_d = wpd_pkg::FifoCntW'(count_d - wpd_pkg::FifoCntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (in_acc) wr_ptr_q <= wpd_pkg::FifoPtrW'(wr_ptr_q + wpd_pkg::FifoPtrW'(n_res));
      if (out_pop) rd_ptr_q <= wpd_pkg::FifoPtrW'(rd_ptr_q + wpd_pkg::FifoPtrW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (n_res != 2'd0) fifo_q[wr_ptr_q] <= res[0];
      if (n_res == 2'd2) fifo_q[wpd_pkg::FifoPtrW'(wr_ptr_q + 1'b1)] <= res[1];
    end
  end

  assign out_o.valid           = (count_q != '0);
  assign out_o.kind            = fifo_q[rd_ptr_q].kind;
  assign out_o.channel         = fifo_q[rd_ptr_q].channel;
  assign out_o.sample_value    = fifo_q[rd_ptr_q].sample_value;
  assign out_o.is_float        = fifo_q[rd_ptr_q].is_float;
  assign out_o.format_tag      = fifo_q[rd_ptr_q].format_tag;
  assign out_o.channel_count   = fifo_q[rd_ptr_q].channel_count;
  assign out_o.rate_hz         = fifo_q[rd_ptr_q].rate_hz;
  assign out_o.bits_per_sample = fifo_q[rd_ptr_q].bits_per_sample;
  assign out_o.data_len        = fifo_q[rd_ptr_q].data_len;
  assign out_o.error_code      = fifo_q[rd_ptr_q].error_code;
  assign out_o.last            = fifo_q[rd_ptr_q].last;

endmodule

// File: rtl/wpd_checker.sv
// Port-level checker for the WAV parser, bound to the top level.
module wpd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic        [1:0]  kind_i,
  input logic signed [31:0] sample_value_i,
  input logic        [15:0] format_tag_i,
  input logic        [31:0] data_len_i,
  input logic        [2:0]  error_code_i,
  input logic               last_i
);

  // a stalled result keeps valid asserted
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_sample_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == wpd_pkg::KIND_SAMPLE |->
      format_tag_i == 16'd0 && data_len_i == 32'd0 && error_code_i == wpd_pkg::ERR_NONE)
    else $error("sample word carries report or error fields");

  a_fail_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == wpd_pkg::KIND_FAIL |->
      error_code_i != wpd_pkg::ERR_NONE && error_code_i <= wpd_pkg::ERR_BITS &&
      sample_value_i == 32'sd0)
    else $error("failure word without a valid error code");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == wpd_pkg::KIND_END |-> last_i && error_code_i == wpd_pkg::ERR_NONE)
    else $error("end of stream word not marked last");

endmodule

bind wav_stream_parse_decode wpd_checker u_wpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .sample_value_i (out_o.sample_value),
  .format_tag_i   (out_o.format_tag),
  .data_len_i     (out_o.data_len),
  .error_code_i   (out_o.error_code),
  .last_i         (out_o.last)
);
